/* rtl/core/bqc_pkg.sv */
// shared types, constants and arithmetic helpers for the biquad cascade
`timescale 1ns / 1ps

package bqc_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int COEF_WIDTH   = 24;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFRAC        = COEF_WIDTH - 4;
    localparam int SFRAC        = SAMPLE_WIDTH - 1;
    localparam int ALIGN_SHIFT  = CFRAC - SFRAC;
    localparam int NUM_COEFS    = 6;
    localparam int SEC_W        = $clog2(MAX_SECTIONS);
    localparam int CSEL_W       = 3;
    localparam int ACT_W        = 2;
    localparam int CFG_W        = 4;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int PROD_W       = 2 * COEF_WIDTH;
    localparam int ACC_W        = PROD_W + 3;
    localparam int ROW_W        = NUM_COEFS * COEF_WIDTH;
    localparam int HIST_W       = 4 * COEF_WIDTH;

    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic signed [COEF_WIDTH:0]     wide_t;
    typedef logic [ROW_W-1:0]               coef_row_t;
    typedef logic [HIST_W-1:0]              hist_row_t;
    typedef logic [SEC_W-1:0]               sec_t;
    typedef logic [ACT_W-1:0]               action_t;
    typedef logic [CSEL_W-1:0]              csel_t;
    typedef logic [CFG_W-1:0]               cfg_t;

    localparam action_t ACT_FILTER = ACT_W'(0);
    localparam action_t ACT_LOAD   = ACT_W'(1);
    localparam action_t ACT_CLEAR  = ACT_W'(2);

    localparam csel_t CSEL_GAIN = CSEL_W'(0);
    localparam csel_t CSEL_B0   = CSEL_W'(1);
    localparam csel_t CSEL_B1   = CSEL_W'(2);
    localparam csel_t CSEL_B2   = CSEL_W'(3);
    localparam csel_t CSEL_A1   = CSEL_W'(4);
    localparam csel_t CSEL_A2   = CSEL_W'(5);

    localparam int HIST_X1 = 0;
    localparam int HIST_X2 = 1;
    localparam int HIST_Y1 = 2;
    localparam int HIST_Y2 = 3;

    localparam logic [APB_AW-3:0] REG_SECTIONS   = '0;
    localparam cfg_t              SECTIONS_RESET = CFG_W'(MAX_SECTIONS);

    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_WR,
        S_GAIN,
        S_MAC,
        S_SUM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  of;
        coef_t val;
    } coef_sat_t;

    typedef struct packed {
        logic    of;
        sample_t val;
    } sample_sat_t;

    // butterworth sections, q3.20
    localparam coef_t INIT_TAB [MAX_SECTIONS][NUM_COEFS] = '{
        '{24'sd94676, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1604208, 24'sd934335},
        '{24'sd85536, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1449338, 24'sd742905},
        '{24'sd78405, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1328524, 24'sd593570},
        '{24'sd72934, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1235813, 24'sd478973},
        '{24'sd68848, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1166580, 24'sd393396},
        '{24'sd65945, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1117396, 24'sd332601},
        '{24'sd64084, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1085861, 24'sd293622},
        '{24'sd63175, 24'sd1048576, 24'sd2097152, 24'sd1048576, -24'sd1070460, 24'sd274586}
    };

    function automatic coef_row_t init_row(sec_t s);
        coef_row_t r;
        r = '0;
        for (int j = 0; j < NUM_COEFS; j++)
        begin
            r[j*COEF_WIDTH +: COEF_WIDTH] = INIT_TAB[s][j];
        end
        return r;
    endfunction

    // round half up to the coefficient grid
    function automatic acc_t round_cf(acc_t v);
        return (v + (acc_t'(1) <<< (CFRAC - 1))) >>> CFRAC;
    endfunction

    function automatic coef_sat_t sat_coef(acc_t v);
        coef_sat_t r;
        r.of  = 1'b0;
        r.val = coef_t'(v);
        if (v > acc_t'(COEF_MAX))
        begin
            r.of  = 1'b1;
            r.val = COEF_MAX;
        end
        else if (v < acc_t'(COEF_MIN))
        begin
            r.of  = 1'b1;
            r.val = COEF_MIN;
        end
        return r;
    endfunction

    function automatic sample_sat_t sat_sample(coef_t y);
        sample_sat_t r;
        wide_t       t;
        t     = (wide_t'(y) + (wide_t'(1) <<< (ALIGN_SHIFT - 1))) >>> ALIGN_SHIFT;
        r.of  = 1'b0;
        r.val = sample_t'(t);
        if (t > wide_t'(SAMPLE_MAX))
        begin
            r.of  = 1'b1;
            r.val = SAMPLE_MAX;
        end
        else if (t < wide_t'(SAMPLE_MIN))
        begin
            r.of  = 1'b1;
            r.val = SAMPLE_MIN;
        end
        return r;
    endfunction

endpackage

/* rtl/core/bqc_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module bqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/biquad_cascade_iir_filter.sv */
// biquad cascade top level: request decode, section sequencer, datapath, apb register
// filter request: steps through gain, mac and sum for each of n active sections (1..8),
// then the done step raises out_valid; a new request is accepted only back in idle
// load request does a row read, then a merged write; clear and no-op requests stay idle
// reset: coefficients read as the butterworth table and history as zero through per-row
// valid bits, so no clearing pass is needed; sections_reg resets to 8
`timescale 1ns / 1ps

module biquad_cascade_iir_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqc_pkg::APB_AW-1:0]          paddr,
    input  logic [bqc_pkg::APB_DW-1:0]          pwdata,
    output logic [bqc_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bqc_pkg::action_t                    action,
    input  bqc_pkg::sample_t                    sample_in,
    input  bqc_pkg::sec_t                       section,
    input  bqc_pkg::csel_t                      coef_select,
    input  bqc_pkg::coef_t                      coef_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bqc_pkg::sample_t                    sample_out,
    output logic                                overflow
);

    import bqc_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    cfg_t        sections_reg;
    sec_t        sec_reg;
    sec_t        last_sec;
    coef_t       x_reg;
    coef_t       xg_reg;
    prod_t       p0_reg;
    prod_t       p1_reg;
    prod_t       p2_reg;
    prod_t       p3_reg;
    prod_t       p4_reg;
    acc_t        psum_reg;
    logic        of_reg;
    sample_t     fin_sample_reg;
    logic        fin_of_reg;
    csel_t       csel_reg;
    coef_t       cval_reg;
    logic [MAX_SECTIONS-1:0] coef_valid_reg;
    logic [MAX_SECTIONS-1:0] hist_valid_reg;
    logic        out_valid_reg;
    sample_t     sample_out_reg;
    logic        overflow_reg;

    logic        in_fire;
    logic        cfg_write;
    logic        reg_hit;
    logic        coef_re;
    logic        coef_we;
    sec_t        coef_raddr;
    logic        hist_re;
    logic        hist_we;
    sec_t        hist_raddr;
    coef_row_t   coef_rdata;
    hist_row_t   hist_rdata;
    coef_row_t   coef_row;
    coef_row_t   coef_wdata;
    hist_row_t   hist_row;
    hist_row_t   hist_wdata;
    coef_t       c_gain;
    coef_t       c_b0;
    coef_t       c_b1;
    coef_t       c_b2;
    coef_t       c_a1;
    coef_t       c_a2;
    coef_t       h_x1;
    coef_t       h_x2;
    coef_t       h_y1;
    coef_t       h_y2;
    prod_t       g_prod;
    prod_t       m0;
    prod_t       m1;
    prod_t       m2;
    prod_t       m3;
    prod_t       m4;
    coef_sat_t   gain_sat;
    coef_sat_t   y_sat;
    sample_sat_t out_sat;
    coef_t       x_in;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_hit   = (paddr[APB_AW-1:2] == REG_SECTIONS);
    assign prdata    = reg_hit ? APB_DW'(sections_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sections_reg <= SECTIONS_RESET;
        end
        else if (cfg_write && reg_hit)
        begin
            sections_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (sections_reg == '0)
        begin
            last_sec = '0;
        end
        else if (sections_reg > CFG_W'(MAX_SECTIONS))
        begin
            last_sec = SEC_W'(MAX_SECTIONS - 1);
        end
        else
        begin
            last_sec = SEC_W'(sections_reg - CFG_W'(1));
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // state memories
    bqc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SECTIONS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (sec_reg),
        .wdata (coef_wdata),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_SECTIONS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (sec_reg),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign coef_row = coef_valid_reg[sec_reg] ? coef_rdata : init_row(sec_reg);
    assign hist_row = hist_valid_reg[sec_reg] ? hist_rdata : '0;

    assign c_gain = coef_t'(coef_row[CSEL_GAIN*COEF_WIDTH +: COEF_WIDTH]);
    assign c_b0   = coef_t'(coef_row[CSEL_B0*COEF_WIDTH +: COEF_WIDTH]);
    assign c_b1   = coef_t'(coef_row[CSEL_B1*COEF_WIDTH +: COEF_WIDTH]);
    assign c_b2   = coef_t'(coef_row[CSEL_B2*COEF_WIDTH +: COEF_WIDTH]);
    assign c_a1   = coef_t'(coef_row[CSEL_A1*COEF_WIDTH +: COEF_WIDTH]);
    assign c_a2   = coef_t'(coef_row[CSEL_A2*COEF_WIDTH +: COEF_WIDTH]);
    assign h_x1   = coef_t'(hist_row[HIST_X1*COEF_WIDTH +: COEF_WIDTH]);
    assign h_x2   = coef_t'(hist_row[HIST_X2*COEF_WIDTH +: COEF_WIDTH]);
    assign h_y1   = coef_t'(hist_row[HIST_Y1*COEF_WIDTH +: COEF_WIDTH]);
    assign h_y2   = coef_t'(hist_row[HIST_Y2*COEF_WIDTH +: COEF_WIDTH]);

    // datapath arithmetic
    assign x_in     = coef_t'($signed({sample_in, {ALIGN_SHIFT{1'b0}}}));
    assign g_prod   = x_reg * c_gain;
    assign gain_sat = sat_coef(round_cf(acc_t'(g_prod)));
    assign m0       = xg_reg * c_b0;
    assign m1       = c_b1 * h_x1;
    assign m2       = c_b2 * h_x2;
    assign m3       = c_a1 * h_y1;
    assign m4       = c_a2 * h_y2;
    assign y_sat    = sat_coef(round_cf(acc_t'(p0_reg) + psum_reg));
    assign out_sat  = sat_sample(y_sat.val);

    always_comb
    begin
        coef_wdata = coef_row;
        for (int j = 0; j < NUM_COEFS; j++)
        begin
            if (csel_reg == CSEL_W'(j))
            begin
                coef_wdata[j*COEF_WIDTH +: COEF_WIDTH] = cval_reg;
            end
        end
    end

    always_comb
    begin
        hist_wdata = '0;
        hist_wdata[HIST_X1*COEF_WIDTH +: COEF_WIDTH] = xg_reg;
        hist_wdata[HIST_X2*COEF_WIDTH +: COEF_WIDTH] = h_x1;
        hist_wdata[HIST_Y1*COEF_WIDTH +: COEF_WIDTH] = y_sat.val;
        hist_wdata[HIST_Y2*COEF_WIDTH +: COEF_WIDTH] = h_y1;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        coef_re    = 1'b0;
        coef_we    = 1'b0;
        coef_raddr = '0;
        hist_re    = 1'b0;
        hist_we    = 1'b0;
        hist_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        ACT_FILTER:
                        begin
                            coef_re    = 1'b1;
                            hist_re    = 1'b1;
                            state_next = S_GAIN;
                        end
                        ACT_LOAD:
                        begin
                            if (coef_select < CSEL_W'(NUM_COEFS))
                            begin
                                coef_re    = 1'b1;
                                coef_raddr = section;
                                state_next = S_LOAD_WR;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD_WR:
            begin
                coef_we    = 1'b1;
                state_next = S_IDLE;
            end
            S_GAIN:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                hist_we = 1'b1;
                if (sec_reg == last_sec)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    coef_re    = 1'b1;
                    hist_re    = 1'b1;
                    coef_raddr = sec_reg + SEC_W'(1);
                    hist_raddr = sec_reg + SEC_W'(1);
                    state_next = S_GAIN;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sec_reg  <= (action == ACT_LOAD) ? section : '0;
                    x_reg    <= x_in;
                    of_reg   <= 1'b0;
                    csel_reg <= coef_select;
                    cval_reg <= coef_value;
                end
            end
            S_GAIN:
            begin
                xg_reg <= gain_sat.val;
                of_reg <= of_reg | gain_sat.of;
                p1_reg <= m1;
                p2_reg <= m2;
                p3_reg <= m3;
                p4_reg <= m4;
            end
            S_MAC:
            begin
                p0_reg   <= m0;
                psum_reg <= acc_t'(p1_reg) + acc_t'(p2_reg) - acc_t'(p3_reg) - acc_t'(p4_reg);
            end
            S_SUM:
            begin
                x_reg          <= y_sat.val;
                of_reg         <= of_reg | y_sat.of;
                fin_sample_reg <= out_sat.val;
                fin_of_reg     <= of_reg | y_sat.of | out_sat.of;
                if (sec_reg != last_sec)
                begin
                    sec_reg <= sec_reg + SEC_W'(1);
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= '0;
            hist_valid_reg <= '0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_valid_reg[sec_reg] <= 1'b1;
            end
            if (in_fire && action == ACT_CLEAR)
            begin
                hist_valid_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_valid_reg[sec_reg] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            sample_out_reg <= fin_sample_reg;
            overflow_reg   <= fin_of_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign overflow   = overflow_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done step");

    a_sec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAIN || state_reg == S_MAC || state_reg == S_SUM)
        |-> sec_reg <= last_sec)
        else $error("section counter past the last active section");

    a_coef_write_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        coef_we |-> $past(in_fire) && $past(action) == ACT_LOAD && csel_reg < CSEL_W'(NUM_COEFS))
        else $error("coefficient write without a valid load request");

endmodule
